// ----- src/dqr_pkg.sv -----
// Shared constants, codes and types for the deque with keyed removal.
package dqr_pkg;

  localparam int CAPACITY  = 16;
  localparam int PAYLOAD_W = 32;
  localparam int ID_W      = 32;
  localparam int KIND_W    = 3;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = $clog2(CAPACITY + 1);

  localparam logic [KIND_W-1:0] KIND_PUSH_HEAD = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_TAIL = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_HEAD  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_TAIL  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TAKE      = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic                 valid;
    logic [PAYLOAD_W-1:0] payload;
    logic [ID_W-1:0]      id;
  } entry_t;

  // Broadcast to every cell: op code and whether the op takes effect.
  typedef struct packed {
    logic              en;
    logic [KIND_W-1:0] kind;
  } cmd_t;

endpackage

// ----- src/dqr_if.sv -----
// Request and response channel interfaces.
interface dqr_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] payload_in;
  logic [31:0] target_id;

  modport source (output valid, kind, payload_in, target_id, input ready);
  modport sink   (input valid, kind, payload_in, target_id, output ready);
endinterface

interface dqr_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] payload_out;
  logic [31:0] item_id;
  logic [4:0]  count;

  modport source (output valid, status, payload_out, item_id, count, input ready);
  modport sink   (input valid, status, payload_out, item_id, count, output ready);
endinterface

// ----- src/dqr_cell.sv -----
// One slot of the deque: holds an entry and shifts with its neighbors.
module dqr_cell (
  input  logic            clk,
  input  logic            rst,
  input  dqr_pkg::cmd_t   cmd,
  input  dqr_pkg::entry_t new_entry,
  input  dqr_pkg::entry_t left,
  input  dqr_pkg::entry_t right,
  input  logic [31:0]     target,
  input  logic            prior_hit,
  output dqr_pkg::entry_t entry,
  output logic            hit_seen,
  output logic            hit,
  output dqr_pkg::entry_t sel_entry
);
  import dqr_pkg::*;

  logic                 valid;
  logic [PAYLOAD_W-1:0] payload;
  logic [ID_W-1:0]      id;
  entry_t               entry_next;
  logic                 match;
  logic                 is_tail;
  logic                 is_slot;
  logic                 sel;

  assign entry    = '{valid: valid, payload: payload, id: id};
  assign match    = valid && (id == target);
  assign hit      = match && !prior_hit;
  assign hit_seen = prior_hit || match;
  assign is_tail  = valid && !right.valid;
  assign is_slot  = !valid && left.valid;

  always_comb begin
    entry_next = entry;
    sel        = 1'b0;
    case (cmd.kind)
      KIND_PUSH_HEAD: begin
        entry_next = left;
      end
      KIND_PUSH_TAIL: begin
        if (is_slot) entry_next = new_entry;
      end
      KIND_POP_HEAD: begin
        entry_next = right;
      end
      KIND_POP_TAIL: begin
        sel = is_tail;
        if (is_tail) entry_next.valid = 1'b0;
      end
      KIND_TAKE: begin
        sel = hit;
        // everything from the hit toward the tail moves up one slot
        if (hit_seen) entry_next = right;
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  assign sel_entry = sel ? entry : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.en) begin
      valid <= entry_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.en) begin
      payload <= entry_next.payload;
      id      <= entry_next.id;
    end
  end

endmodule

// ----- src/deque_with_remove_by_id.sv -----
// Top level: bounded deque of stamped entries with removal by serial number.
// Sixteen entries sit in a row of cells, head at cell 0. Each request transfer
// is one of push head, push tail, pop head, pop tail or take-by-serial, and
// returns exactly one response transfer with status (ok, empty/not found,
// full), the removed payload, the serial involved and the entry count after
// the op. A push stamps its entry with the next value of a 32-bit serial
// counter that starts at 1 and wraps; a push into a full deque is refused and
// does not advance the counter. A take removes the matching entry nearest the
// head. Undefined op codes return ok with zero data and leave state alone.
// Throughput is one op per cycle: the cells all shift in the accept cycle and
// the response is registered, so it appears in the cycle after the request
// transfer; a new request is taken while the response register is empty or
// being drained. The cycle time is set by the first-match chain rippling
// through all the cells plus the OR-select of the removed entry.
module deque_with_remove_by_id (
  input logic       clk,
  input logic       rst,
  dqr_req_if.sink   req,
  dqr_rsp_if.source rsp
);
  import dqr_pkg::*;

  // cell row
  entry_t               cells     [CAPACITY];
  entry_t               sel_ent   [CAPACITY];
  logic [CAPACITY:0]    hit_chain;
  logic [CAPACITY-1:0]  hit_vec;
  logic [CAPACITY-1:0]  valid_vec;
  entry_t               new_entry;
  entry_t               removed;
  cmd_t                 cmd;

  // control state
  logic [COUNT_W-1:0]   count;
  logic [COUNT_W-1:0]   count_next;
  logic [ID_W-1:0]      next_serial;
  logic [ID_W-1:0]      serial_inc;

  // response register
  logic                 rsp_valid;
  logic [STATUS_W-1:0]  status;
  logic [STATUS_W-1:0]  status_next;
  logic [PAYLOAD_W-1:0] payload_out;
  logic [PAYLOAD_W-1:0] payload_out_next;
  logic [ID_W-1:0]      item_id;
  logic [ID_W-1:0]      item_id_next;

  logic accept;
  logic full;
  logic empty;
  logic found;
  logic effective;

  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign full       = (count == COUNT_W'(CAPACITY));
  assign empty      = (count == '0);
  assign serial_inc = next_serial + ID_W'(1);
  assign new_entry  = '{valid: 1'b1, payload: req.payload_in[PAYLOAD_W-1:0], id: serial_inc};

  assign hit_chain[0] = 1'b0;
  assign found        = hit_chain[CAPACITY];

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      entry_t left_in;
      entry_t right_in;
      // head cell sees the incoming entry on its left, tail cell sees an empty slot
      if (g == 0) begin : g_head
        assign left_in = new_entry;
      end else begin : g_mid_l
        assign left_in = cells[g-1];
      end
      if (g == CAPACITY - 1) begin : g_tail
        assign right_in = '0;
      end else begin : g_mid_r
        assign right_in = cells[g+1];
      end

      dqr_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .cmd       (cmd),
        .new_entry (new_entry),
        .left      (left_in),
        .right     (right_in),
        .target    (req.target_id),
        .prior_hit (hit_chain[g]),
        .entry     (cells[g]),
        .hit_seen  (hit_chain[g+1]),
        .hit       (hit_vec[g]),
        .sel_entry (sel_ent[g])
      );
      assign valid_vec[g] = cells[g].valid;
    end
  endgenerate

  // at most one cell is selected, so an OR picks the removed entry
  always_comb begin
    removed = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      removed = removed | sel_ent[i];
    end
  end

  // op decode: does it take effect, and what the response says
  always_comb begin
    effective        = 1'b0;
    status_next      = STATUS_OK;
    payload_out_next = '0;
    item_id_next     = '0;
    count_next       = count;
    case (req.kind)
      KIND_PUSH_HEAD, KIND_PUSH_TAIL: begin
        if (full) begin
          status_next = STATUS_FULL;
        end else begin
          effective    = 1'b1;
          item_id_next = serial_inc;
          count_next   = count + COUNT_W'(1);
        end
      end
      KIND_POP_HEAD: begin
        if (empty) begin
          status_next = STATUS_EMPTY;
        end else begin
          effective        = 1'b1;
          payload_out_next = cells[0].payload;
          item_id_next     = cells[0].id;
          count_next       = count - COUNT_W'(1);
        end
      end
      KIND_POP_TAIL: begin
        if (empty) begin
          status_next = STATUS_EMPTY;
        end else begin
          effective        = 1'b1;
          payload_out_next = removed.payload;
          item_id_next     = removed.id;
          count_next       = count - COUNT_W'(1);
        end
      end
      KIND_TAKE: begin
        if (!found) begin
          status_next = STATUS_EMPTY;
        end else begin
          effective        = 1'b1;
          payload_out_next = removed.payload;
          item_id_next     = removed.id;
          count_next       = count - COUNT_W'(1);
        end
      end
      default: begin
        effective = 1'b0;
      end
    endcase
  end

  assign cmd = '{en: accept && effective, kind: req.kind};

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      next_serial <= '0;
    end else if (accept) begin
      count <= count_next;
      if (effective && (req.kind == KIND_PUSH_HEAD || req.kind == KIND_PUSH_TAIL)) begin
        next_serial <= serial_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status      <= status_next;
      payload_out <= payload_out_next;
      item_id     <= item_id_next;
      rsp.count   <= count_next;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.status      = status;
  assign rsp.payload_out = payload_out;
  assign rsp.item_id     = item_id;

`ifndef SYNTH
  localparam logic [CAPACITY:0] ONE_EXT = 1;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_count_cells: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(count))
    else $error("entry count disagrees with occupied cells");

  a_packed_head: assert property (@(posedge clk) disable iff (rst)
    $onehot({1'b0, valid_vec} + ONE_EXT))
    else $error("occupied cells not packed toward the head");

  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    $onehot0(hit_vec))
    else $error("more than one cell claims the first match");

  a_serial_step: assert property (@(posedge clk) disable iff (rst)
    accept && effective && (req.kind == KIND_PUSH_HEAD || req.kind == KIND_PUSH_TAIL)
    |=> next_serial == $past(next_serial) + ID_W'(1))
    else $error("serial counter did not advance on a push");
`endif

endmodule
